// ===== design/krt_pkg.sv =====
// Package for the keyed record table: record type, operation and status codes.
// No dependencies; used by krt_mem and keyed_record_table_compacting.
package krt_pkg;

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncRemove = 2'd1,
    FuncLookup = 2'd2,
    FuncList   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatFull     = 3'd1,
    StatDup      = 3'd2,
    StatNotFound = 3'd3,
    StatEmpty    = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] year;
    logic [31:0] course_a;
    logic [31:0] grade_a;
    logic [31:0] course_b;
    logic [31:0] grade_b;
    logic [31:0] course_c;
    logic [31:0] grade_c;
  } rec_t;

endpackage

// ===== design/krt_mem.sv =====
// Record memory: one write port, one read port with registered read data.
// Depends on krt_pkg (rec_t).
module krt_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  krt_pkg::rec_t     wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output krt_pkg::rec_t     rdata_o
);

  krt_pkg::rec_t mem_q [Depth];
  krt_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/keyed_record_table_compacting.sv =====
// Keyed record table with linear search and compaction on remove.
// Depends on krt_pkg and krt_mem.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// request   | start, busy          | func_i, key_i, year_in_i, course/grade_*_in_i
// result    | res_valid_o (strobe) | status_o, key_out_o, record fields, used_count_o,
//           |                      | full_flag_o, last_o
//
// A request is taken when start is high and busy is low. Search walks the record
// memory one entry per cycle through its single registered read port: insert,
// remove and lookup scan the entries in use, remove then shifts the later entries
// down by one, and list emits one key per cycle from the registered read data.
// Insert into a full table and list of an empty table answer from idle, with no search.
// Reset clears the fill count and control state; the memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_record_table_compacting #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func_i,
  input  logic [31:0]                       key_i,
  input  logic [31:0]                       year_in_i,
  input  logic [31:0]                       course_a_in_i,
  input  logic [31:0]                       grade_a_in_i,
  input  logic [31:0]                       course_b_in_i,
  input  logic [31:0]                       grade_b_in_i,
  input  logic [31:0]                       course_c_in_i,
  input  logic [31:0]                       grade_c_in_i,
  output logic                              res_valid_o,
  output logic [2:0]                        status_o,
  output logic [31:0]                       key_out_o,
  output logic [31:0]                       year_out_o,
  output logic [31:0]                       course_a_out_o,
  output logic [31:0]                       grade_a_out_o,
  output logic [31:0]                       course_b_out_o,
  output logic [31:0]                       grade_b_out_o,
  output logic [31:0]                       course_c_out_o,
  output logic [31:0]                       grade_c_out_o,
  output logic [$clog2(CAPACITY+1)-1:0]     used_count_o,
  output logic                              full_flag_o,
  output logic                              last_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSearch = 4'b0010,
    StShift  = 4'b0100,
    StList   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        dst_q, dst_d;
  logic                   vld_q, vld_d;
  krt_pkg::func_e         func_q;
  krt_pkg::rec_t          req_q;

  logic                   we;
  logic [IdxW-1:0]        waddr;
  krt_pkg::rec_t          wdata;
  krt_pkg::rec_t          rdata;

  logic                   emit;
  krt_pkg::status_e       e_status;
  krt_pkg::rec_t          e_rec;
  logic                   e_last;
  logic                   hit;

  logic                   out_vld_q;
  krt_pkg::status_e       out_status_q;
  krt_pkg::rec_t          out_rec_q;
  logic [CntW-1:0]        out_count_q;
  logic                   out_last_q;

  krt_mem #(
    .Depth(CAPACITY),
    .AddrW(IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[IdxW-1:0]),
    .rdata_o(rdata)
  );

  assign busy = (state_q != StIdle);
  assign hit  = vld_q && (rdata.key == req_q.key);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    dst_d    = dst_q;
    vld_d    = 1'b0;
    we       = 1'b0;
    waddr    = dst_q;
    wdata    = rdata;
    emit     = 1'b0;
    e_status = krt_pkg::StatOk;
    e_rec    = '0;
    e_last   = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          idx_d = '0;
          unique case (krt_pkg::func_e'(func_i))
            krt_pkg::FuncInsert: begin
              if (count_q == Cap) begin
                emit     = 1'b1;
                e_status = krt_pkg::StatFull;
              end else begin
                state_d = StSearch;
              end
            end
            krt_pkg::FuncRemove, krt_pkg::FuncLookup: begin
              state_d = StSearch;
            end
            krt_pkg::FuncList: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = krt_pkg::StatEmpty;
              end else begin
                state_d = StList;
              end
            end
            default: ;
          endcase
        end
      end
      StSearch: begin
        if (hit) begin
          unique case (func_q)
            krt_pkg::FuncInsert: begin
              emit     = 1'b1;
              e_status = krt_pkg::StatDup;
              state_d  = StIdle;
            end
            krt_pkg::FuncLookup: begin
              emit    = 1'b1;
              e_rec   = rdata;
              state_d = StIdle;
            end
            krt_pkg::FuncRemove: begin
              state_d = StShift;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end else if (idx_q >= count_q) begin
          emit    = 1'b1;
          state_d = StIdle;
          if (func_q == krt_pkg::FuncInsert) begin
            we      = 1'b1;
            waddr   = count_q[IdxW-1:0];
            wdata   = req_q;
            count_d = count_q + CntW'(1);
          end else begin
            e_status = krt_pkg::StatNotFound;
          end
        end else begin
          vld_d = 1'b1;
          idx_d = idx_q + CntW'(1);
        end
      end
      StShift: begin
        we = vld_q;
        if (idx_q < count_q) begin
          vld_d = 1'b1;
          dst_d = IdxW'(idx_q - CntW'(1));
          idx_d = idx_q + CntW'(1);
        end else begin
          count_d = count_q - CntW'(1);
          emit    = 1'b1;
          state_d = StIdle;
        end
      end
      StList: begin
        if (vld_q) begin
          emit      = 1'b1;
          e_rec.key = rdata.key;
          e_last    = (idx_q >= count_q);
          if (idx_q >= count_q) begin
            state_d = StIdle;
          end
        end
        if (idx_q < count_q) begin
          vld_d = 1'b1;
          idx_d = idx_q + CntW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      idx_q     <= '0;
      dst_q     <= '0;
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      dst_q     <= dst_d;
      vld_q     <= vld_d;
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q         <= krt_pkg::func_e'(func_i);
      req_q.key      <= key_i;
      req_q.year     <= year_in_i;
      req_q.course_a <= course_a_in_i;
      req_q.grade_a  <= grade_a_in_i;
      req_q.course_b <= course_b_in_i;
      req_q.grade_b  <= grade_b_in_i;
      req_q.course_c <= course_c_in_i;
      req_q.grade_c  <= grade_c_in_i;
    end
    if (emit) begin
      out_status_q <= e_status;
      out_rec_q    <= e_rec;
      out_count_q  <= count_d;
      out_last_q   <= e_last;
    end
  end

  assign res_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign key_out_o      = out_rec_q.key;
  assign year_out_o     = out_rec_q.year;
  assign course_a_out_o = out_rec_q.course_a;
  assign grade_a_out_o  = out_rec_q.grade_a;
  assign course_b_out_o = out_rec_q.course_b;
  assign grade_b_out_o  = out_rec_q.grade_b;
  assign course_c_out_o = out_rec_q.course_c;
  assign grade_c_out_o  = out_rec_q.grade_c;
  assign used_count_o   = out_count_q;
  assign full_flag_o    = (out_count_q == Cap);
  assign last_o         = out_last_q;

endmodule

// ===== tb/tb.sv =====
// Testbench for keyed_record_table_compacting: directed and random requests
// checked against a shadow copy of the record table. Depends on krt_pkg.

typedef struct {
  logic [2:0]    status;
  krt_pkg::rec_t rec;
  logic [4:0]    used;
  logic          full;
  logic          last;
} table_reply_t;

class keyed_table_shadow;
  int            cap;
  krt_pkg::rec_t rows[$];
  table_reply_t  pending[$];
  int            failures;
  int            shown;
  int            checked;
  int            full_refusals;
  int            op_count[4];

  function new(int cap_i);
    cap = cap_i;
  endfunction

  function int find_key(logic [31:0] k);
    foreach (rows[i]) begin
      if (rows[i].key == k) return i;
    end
    return -1;
  endfunction

  function void push_reply(krt_pkg::status_e st, krt_pkg::rec_t r, bit fin);
    table_reply_t x;
    x.status = st;
    x.rec    = r;
    x.used   = 5'(rows.size());
    x.full   = (rows.size() == cap);
    x.last   = fin;
    pending.push_back(x);
  endfunction

  function void apply_request(krt_pkg::func_e fn, krt_pkg::rec_t req);
    int            slot;
    krt_pkg::rec_t blank;
    krt_pkg::rec_t key_only;
    blank = '0;
    op_count[fn]++;
    case (fn)
      krt_pkg::FuncInsert: begin
        if (rows.size() >= cap) begin
          full_refusals++;
          push_reply(krt_pkg::StatFull, blank, 1'b1);
        end else if (find_key(req.key) >= 0) begin
          push_reply(krt_pkg::StatDup, blank, 1'b1);
        end else begin
          rows.push_back(req);
          push_reply(krt_pkg::StatOk, blank, 1'b1);
        end
      end
      krt_pkg::FuncRemove: begin
        slot = find_key(req.key);
        if (slot < 0) begin
          push_reply(krt_pkg::StatNotFound, blank, 1'b1);
        end else begin
          rows.delete(slot);
          push_reply(krt_pkg::StatOk, blank, 1'b1);
        end
      end
      krt_pkg::FuncLookup: begin
        slot = find_key(req.key);
        if (slot < 0) push_reply(krt_pkg::StatNotFound, blank, 1'b1);
        else push_reply(krt_pkg::StatOk, rows[slot], 1'b1);
      end
      default: begin
        if (rows.size() == 0) begin
          push_reply(krt_pkg::StatEmpty, blank, 1'b1);
        end else begin
          foreach (rows[i]) begin
            key_only = '0;
            key_only.key = rows[i].key;
            push_reply(krt_pkg::StatOk, key_only, i == rows.size() - 1);
          end
        end
      end
    endcase
  endfunction

  function void flag(string what, logic [31:0] e, logic [31:0] a);
    failures++;
    if (shown < 10) begin
      shown++;
      $display("mismatch on %s: expected %h, got %h", what, e, a);
    end
  endfunction

  function void check(string what, logic [31:0] e, logic [31:0] a);
    if (e !== a) flag(what, e, a);
  endfunction

  function void compare_result(table_reply_t act);
    table_reply_t exp;
    string fld[8] = '{"key_out", "year_out", "course_a_out", "grade_a_out",
                      "course_b_out", "grade_b_out", "course_c_out", "grade_c_out"};
    checked++;
    if (pending.size() == 0) begin
      flag("unexpected result, status", 'x, act.status);
      return;
    end
    exp = pending.pop_front();
    check("status", exp.status, act.status);
    for (int i = 0; i < 8; i++) begin
      check(fld[i], exp.rec[255 - 32 * i -: 32], act.rec[255 - 32 * i -: 32]);
    end
    check("used_count", exp.used, act.used);
    check("full_flag", exp.full, act.full);
    check("last", exp.last, act.last);
  endfunction
endclass

module tb;
  localparam int CAPACITY    = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 350;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [31:0] key_i, year_in_i;
  logic [31:0] course_a_in_i, grade_a_in_i, course_b_in_i, grade_b_in_i;
  logic [31:0] course_c_in_i, grade_c_in_i;
  logic        res_valid_o;
  logic [2:0]  status_o;
  logic [31:0] key_out_o, year_out_o;
  logic [31:0] course_a_out_o, grade_a_out_o, course_b_out_o, grade_b_out_o;
  logic [31:0] course_c_out_o, grade_c_out_o;
  logic [4:0]  used_count_o;
  logic        full_flag_o;
  logic        last_o;

  keyed_table_shadow shadow;
  table_reply_t      observed;
  int                idle_pct;
  int                stall_cycles;
  logic [31:0]       key_pool[24];

  keyed_record_table_compacting #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .key_i         (key_i),
    .year_in_i     (year_in_i),
    .course_a_in_i (course_a_in_i),
    .grade_a_in_i  (grade_a_in_i),
    .course_b_in_i (course_b_in_i),
    .grade_b_in_i  (grade_b_in_i),
    .course_c_in_i (course_c_in_i),
    .grade_c_in_i  (grade_c_in_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .key_out_o     (key_out_o),
    .year_out_o    (year_out_o),
    .course_a_out_o(course_a_out_o),
    .grade_a_out_o (grade_a_out_o),
    .course_b_out_o(course_b_out_o),
    .grade_b_out_o (grade_b_out_o),
    .course_c_out_o(course_c_out_o),
    .grade_c_out_o (grade_c_out_o),
    .used_count_o  (used_count_o),
    .full_flag_o   (full_flag_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic krt_pkg::rec_t rand_rec(logic [31:0] k);
    krt_pkg::rec_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r.key = k;
    return r;
  endfunction

  task automatic send_request(krt_pkg::func_e fn, krt_pkg::rec_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    func_i        <= fn;
    key_i         <= req.key;
    year_in_i     <= req.year;
    course_a_in_i <= req.course_a;
    grade_a_in_i  <= req.grade_a;
    course_b_in_i <= req.course_b;
    grade_b_in_i  <= req.grade_b;
    course_c_in_i <= req.course_c;
    grade_c_in_i  <= req.grade_c;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    shadow.apply_request(fn, req);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      observed.status        = status_o;
      observed.rec.key       = key_out_o;
      observed.rec.year      = year_out_o;
      observed.rec.course_a  = course_a_out_o;
      observed.rec.grade_a   = grade_a_out_o;
      observed.rec.course_b  = course_b_out_o;
      observed.rec.grade_b   = grade_b_out_o;
      observed.rec.course_c  = course_c_out_o;
      observed.rec.grade_c   = grade_c_out_o;
      observed.used          = used_count_o;
      observed.full          = full_flag_o;
      observed.last          = last_o;
      shadow.compare_result(observed);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("keyed_record_table_compacting verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    krt_pkg::func_e fn;
    logic [31:0]    k;
    int             ins_pct;
    int             roll;
    int             kr;
    int             n;

    shadow        = new(CAPACITY);
    idle_pct      = 6;
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = krt_pkg::FuncInsert;
    key_i         = '0;
    year_in_i     = '0;
    course_a_in_i = '0;
    grade_a_in_i  = '0;
    course_b_in_i = '0;
    grade_b_in_i  = '0;
    course_c_in_i = '0;
    grade_c_in_i  = '0;
    key_pool[0]   = '0;
    key_pool[1]   = '1;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: list, misses
    send_request(krt_pkg::FuncList, rand_rec($urandom));
    send_request(krt_pkg::FuncLookup, rand_rec($urandom));
    send_request(krt_pkg::FuncRemove, rand_rec($urandom));
    // field extremes, duplicate, front removal
    send_request(krt_pkg::FuncInsert, '0);
    send_request(krt_pkg::FuncInsert, '1);
    send_request(krt_pkg::FuncInsert, rand_rec('1));
    send_request(krt_pkg::FuncLookup, rand_rec('1));
    send_request(krt_pkg::FuncRemove, rand_rec('0));
    while (shadow.rows.size() < CAPACITY) send_request(krt_pkg::FuncInsert, rand_rec($urandom));
    // full takes precedence over duplicate
    send_request(krt_pkg::FuncInsert, rand_rec('1));
    send_request(krt_pkg::FuncList, rand_rec($urandom));
    send_request(krt_pkg::FuncLookup, rand_rec(shadow.rows[CAPACITY - 1].key));
    send_request(krt_pkg::FuncRemove, rand_rec(shadow.rows[7].key));
    send_request(krt_pkg::FuncLookup, rand_rec(shadow.rows[7].key));
    send_request(krt_pkg::FuncRemove, rand_rec(shadow.rows[shadow.rows.size() - 1].key));

    ins_pct = 85;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0 && n != 0) ins_pct = $urandom_range(15, 75);
      idle_pct = (n >= 120 && n < 220) ? 0 : 6;
      roll = $urandom_range(99);
      if (roll < ins_pct) fn = krt_pkg::FuncInsert;
      else if (roll < ins_pct + (100 - ins_pct) * 2 / 5) fn = krt_pkg::FuncRemove;
      else if (roll < ins_pct + (100 - ins_pct) * 4 / 5) fn = krt_pkg::FuncLookup;
      else fn = krt_pkg::FuncList;
      kr = $urandom_range(99);
      if (fn != krt_pkg::FuncInsert && kr < 60 && shadow.rows.size() > 0)
        k = shadow.rows[$urandom_range(shadow.rows.size() - 1)].key;
      else if (kr < 92) k = key_pool[$urandom_range(23)];
      else k = $urandom;
      send_request(fn, rand_rec(k));
    end
    start <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);

    $display("%0d requests: %0d insert, %0d remove, %0d lookup, %0d list",
             shadow.op_count[0] + shadow.op_count[1] + shadow.op_count[2] + shadow.op_count[3],
             shadow.op_count[0], shadow.op_count[1], shadow.op_count[2], shadow.op_count[3]);
    $display("%0d results checked, %0d inserts refused on a full table, %0d failures",
             shadow.checked, shadow.full_refusals, shadow.failures);
    if (shadow.failures == 0) begin
      $display("keyed_record_table_compacting verification clean");
    end else begin
      $display("keyed_record_table_compacting verification failed");
    end
    $finish;
  end
endmodule
